// ===== hw/rtl/lpf_pkg.sv =====
// lpf_pkg: operation codes, status codes and controller state type for the
// length prefixed packet fifo. No dependencies.
`default_nettype none

package lpf_pkg;

  // operation codes carried on the input tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // status codes carried on the output tuser
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_EMPTY    = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_TOO_LONG = 3'd3;
  localparam logic [2:0] STAT_NOW_FULL = 3'd4;

  // absolute cap on bytes per packet, set by the 9-bit length field
  localparam int unsigned LEN_CAP = 256;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_FETCH = 2'b10
  } lpf_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/length_prefixed_packet_fifo.sv =====
// length_prefixed_packet_fifo: ring of packet slots with byte write/read ops.
// Depends on lpf_pkg and lpf_ram.
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+-------------------------------
//   s_axis    | in        | tvalid/tready         | tuser opcode, tdata byte, tlast
//   m_axis    | out       | tvalid/tready         | tuser status, tdata byte+length,
//             |           |                       | tlast end of packet
//   cfg       | in        | we, no back-pressure  | block_limit (9 bits)
//
// ops: write, clear and unused ops load their result as they are taken; a read op
//   first passes through the fetch state, set by the registered read of the slot and
//   length rams (the ring index is held during the fetch)
// reset: indices, fill/drain offsets and block_limit (256) reset at once; the
//   rams are not cleared, no entry can be read before it is committed
// stalls: the next item is taken only in a cycle where the output register is
//   empty or its result is taken; input also stalls while a read is fetching
`default_nettype none

module length_prefixed_packet_fifo
  import lpf_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned SLOT_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config
  input  wire logic        cfg_we_i,
  input  wire logic [8:0]  cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  input  wire logic        s_axis_tlast_i,   // in_last
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o,   // [7:0] out_byte, [16:8] packet_length
  output logic [2:0]       m_axis_tuser_o,   // [2:0] status
  output logic             m_axis_tlast_o    // out_last
);

  localparam int unsigned SW    = $clog2(SLOT_COUNT);
  localparam int unsigned DEPTH = SLOT_COUNT * SLOT_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);
  // effective per-packet cap from the slot size and the length field
  localparam logic [8:0] LIM_CAP = (SLOT_BYTES < LEN_CAP) ? 9'(SLOT_BYTES) : 9'(LEN_CAP);

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (s == LAST_SLOT) ? '0 : s + SW'(1);
  endfunction

  // control state
  lpf_state_e    state_q, state_d;
  logic [SW-1:0] head_q, head_d;
  logic [SW-1:0] tail_q, tail_d;
  logic [8:0]    fill_q, fill_d;
  logic [8:0]    drain_q, drain_d;
  logic [8:0]    limit_q;
  logic          out_valid_q, out_valid_d;

  // output payload
  logic [2:0] out_status_q, out_status_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;
  logic [8:0] out_len_q, out_len_d;
  logic       out_load;

  // ram side
  logic          st_we, len_we, rd_en;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [8:0]    len_wdata;
  logic [7:0]    st_rdata;
  logic [8:0]    len_rdata;

  logic       in_xfer;
  logic       wr_full;
  logic [8:0] eff_limit;
  logic       rd_empty;
  logic       rd_done;
  logic [8:0] drain_inc;

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);

  assign wr_full   = (next_slot(tail_q) == head_q);
  assign eff_limit = (limit_q < LIM_CAP) ? limit_q : LIM_CAP;
  assign rd_empty  = (head_q == tail_q);
  assign drain_inc = drain_q + 9'd1;

  // slot byte addresses: slot base by constant multiply plus offset
  assign st_waddr = AW'(tail_q) * AW'(SLOT_BYTES) + AW'(fill_q);
  assign st_raddr = AW'(head_q) * AW'(SLOT_BYTES) + AW'(drain_q);

  // fetch both the length and the byte at the head as the read op is taken
  assign rd_en = in_xfer && (s_axis_tuser_i == OP_READ);

  // packet is exhausted, or nothing left in the slot to return
  assign rd_done = (len_rdata == 9'd0) || (drain_q >= len_rdata)
                   || (17'(drain_q) >= 17'(SLOT_BYTES));

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    drain_d      = drain_q;
    st_we        = 1'b0;
    len_we       = 1'b0;
    len_wdata    = fill_q;
    out_load     = 1'b0;
    out_status_d = STAT_OK;
    out_byte_d   = 8'd0;
    out_last_d   = 1'b0;
    out_len_d    = 9'd0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_axis_tuser_i)
            OP_WRITE: begin
              out_load = 1'b1;
              if (wr_full) begin
                // drop byte and discard the open packet
                out_status_d = STAT_FULL;
                fill_d       = 9'd0;
              end else begin
                if (fill_q >= eff_limit) begin
                  out_status_d = STAT_TOO_LONG;
                end else begin
                  st_we  = 1'b1;
                  fill_d = fill_q + 9'd1;
                end
                if (s_axis_tlast_i) begin
                  // commit with the bytes accepted so far
                  len_we    = 1'b1;
                  len_wdata = fill_d;
                  tail_d    = next_slot(tail_q);
                  fill_d    = 9'd0;
                  if (out_status_d == STAT_OK && next_slot(tail_d) == head_q) begin
                    out_status_d = STAT_NOW_FULL;
                  end
                end
              end
            end
            OP_READ: begin
              state_d = ST_FETCH;
            end
            OP_CLEAR: begin
              out_load = 1'b1;
              head_d   = '0;
              tail_d   = '0;
              fill_d   = 9'd0;
              drain_d  = 9'd0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        state_d  = ST_IDLE;
        out_load = 1'b1;
        if (rd_empty) begin
          out_status_d = STAT_EMPTY;
        end else begin
          out_len_d = len_rdata;
          if (rd_done) begin
            out_last_d = 1'b1;
          end else begin
            out_byte_d = st_rdata;
            drain_d    = drain_inc;
            out_last_d = (drain_inc >= len_rdata);
          end
          if (out_last_d) begin
            // slot fully drained, free it
            head_d  = next_slot(head_q);
            drain_d = 9'd0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= 9'd0;
      drain_q     <= 9'd0;
      limit_q     <= 9'(LEN_CAP);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_byte_q   <= out_byte_d;
      out_last_q   <= out_last_d;
      out_len_q    <= out_len_d;
    end
  end

  lpf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (rd_en),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  lpf_ram #(
    .WIDTH (9),
    .DEPTH (SLOT_COUNT)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (tail_q),
    .wdata_i (len_wdata),
    .re_i    (rd_en),
    .raddr_i (head_q),
    .rdata_o (len_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_len_q, out_byte_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

  // the open packet never grows past the effective cap
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= LIM_CAP)
    else $error("fill offset beyond packet cap");

  // a taken read op always fetches in the next cycle
  a_read_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser_i == OP_READ) |=> (state_q == ST_FETCH))
    else $error("read op did not enter fetch");

  // a fetch always leaves a result in the output register
  a_fetch_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> out_valid_q)
    else $error("fetch produced no result");

  // a commit into a non-full ring never makes it look empty
  a_commit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser_i == OP_WRITE && s_axis_tlast_i && !wr_full)
      |=> (tail_q != head_q))
    else $error("commit left ring empty");

  // the input is never taken while a read is in flight
  a_no_take_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> !in_xfer)
    else $error("input taken during fetch");

endmodule

`default_nettype wire

// ===== hw/rtl/lpf_ram.sv =====
// lpf_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.
`default_nettype none

module lpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// testbench for length_prefixed_packet_fifo: random and directed op streams
// checked transfer by transfer against a behavioral model of the slot ring
// depends on lpf_pkg and the rtl of length_prefixed_packet_fifo
`default_nettype none

module testbench;
  import lpf_pkg::*;

  // opcode with no defined action, answered with status ok
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // cycles with no transfer on either side before the run is called hung
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASES = 10;

  // behavioral model of the slot ring plus the queue of results it predicts
  class ring_tracker;
    localparam int unsigned SLOTS = 16;
    localparam int unsigned SLOT_BYTES = 256;

    typedef struct packed {
      logic [2:0] status;
      logic [7:0] data;
      logic       last;
      logic [8:0] length;
    } result_t;

    bit [7:0]    payload [SLOTS*SLOT_BYTES];
    bit [8:0]    lengths [SLOTS];
    int unsigned head, tail, fill, drain;
    bit [8:0]    limit;
    result_t     awaited [$];
    int unsigned seen, errors;

    function new();
      head = 0;
      tail = 0;
      fill = 0;
      drain = 0;
      limit = 9'd256;
      seen = 0;
      errors = 0;
    endfunction

    function void set_limit(bit [8:0] v);
      limit = v;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // advance the model by one accepted input and queue the result it owes
    function void note_input(logic [1:0] op, logic [7:0] b, logic l);
      result_t     r;
      int unsigned cap;
      int unsigned len;
      r = '0;
      r.status = STAT_OK;
      case (op)
        OP_WRITE: begin
          if ((tail + 1) % SLOTS == head) begin
            // ring full: byte dropped and the open packet thrown away
            r.status = STAT_FULL;
            fill = 0;
          end else begin
            cap = (limit > 256) ? 256 : limit;
            if (fill >= cap) begin
              r.status = STAT_TOO_LONG;
            end else begin
              payload[tail*SLOT_BYTES + fill] = b;
              fill++;
            end
            if (l) begin
              lengths[tail] = fill[8:0];
              tail = (tail + 1) % SLOTS;
              fill = 0;
              if (r.status == STAT_OK && (tail + 1) % SLOTS == head) r.status = STAT_NOW_FULL;
            end
          end
        end
        OP_READ: begin
          if (head == tail) begin
            r.status = STAT_EMPTY;
          end else begin
            len = lengths[head];
            r.length = len[8:0];
            if (len == 0 || drain >= len) begin
              r.last = 1'b1;
            end else begin
              r.data = payload[head*SLOT_BYTES + drain];
              drain++;
              r.last = (drain >= len);
            end
            if (r.last) begin
              head = (head + 1) % SLOTS;
              drain = 0;
            end
          end
        end
        OP_CLEAR: begin
          head = 0;
          tail = 0;
          fill = 0;
          drain = 0;
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    task flag_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      $display("mismatch at result %0d: %s got %0d, expected %0d", seen, what, got, want);
    endtask

    task check_result(logic [2:0] status, logic [7:0] data, logic last, logic [8:0] length);
      result_t want;
      seen++;
      if (awaited.size() == 0) begin
        flag_mismatch("result with nothing pending, status", status, 0);
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status) flag_mismatch("status", status, want.status);
      if (data !== want.data) flag_mismatch("out_byte", data, want.data);
      if (last !== want.last) flag_mismatch("out_last", last, want.last);
      if (length !== want.length) flag_mismatch("packet_length", length, want.length);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = OP_WRITE;
  logic        s_tlast = 1'b0;
  logic        m_tready = 1'b1;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire [23:0]  m_axis_tdata_o;
  wire [2:0]   m_axis_tuser_o;
  wire         m_axis_tlast_o;

  ring_tracker ring;
  bit          jitter_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned limit_steps [PHASES] = '{1, 0, 256, 511, 7, 2, 100, 256, 16, 3};
  int unsigned write_pct [PHASES] = '{70, 60, 65, 80, 55, 75, 60, 70, 50, 65};

  length_prefixed_packet_fifo dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // random receiver back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // every output transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid_o && m_tready)
      ring.check_result(m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tlast_o,
                        m_axis_tdata_o[16:8]);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // one input transfer, with an occasional gap in front; valid stays high
  // after the transfer so back-to-back items need no second assignment
  task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic l);
    if (jitter_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= b;
    s_tlast <= l;
    @(posedge clk);
    while (!s_axis_tready_o) @(posedge clk);
    ring.note_input(op, b, l);
  endtask

  // drop valid and wait until every predicted result has been seen
  task automatic end_phase();
    s_tvalid <= 1'b0;
    while (ring.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [8:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring.set_limit(v);
  endtask

  // mostly short packets; near the limit when it is small, rarely long
  function automatic int unsigned pick_length();
    int unsigned cap;
    int unsigned r;
    cap = (ring.limit > 256) ? 256 : ring.limit;
    r = $urandom_range(0, 19);
    if (cap <= 16 && r < 5) return (cap == 0) ? 1 : cap + $urandom_range(0, 1);
    if (r == 0) return $urandom_range(1, cap + 1);
    return $urandom_range(1, 6);
  endfunction

  // one packet of random bytes, sometimes with reads mixed in and
  // sometimes left open so the next packet runs on into it
  task automatic send_packet(input int unsigned len);
    bit truncated;
    truncated = ($urandom_range(0, 14) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(OP_WRITE, 8'($urandom_range(0, 255)), (i == len - 1) && !truncated);
    end
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned wr_pct);
    int unsigned target;
    int unsigned pick;
    target = ring.seen + ring.pending() + n;
    while (ring.seen + ring.pending() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < 5) begin
        send_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (pick < wr_pct) begin
        send_packet(pick_length());
      end else begin
        repeat ($urandom_range(1, 16))
          send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    ring = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // read of an empty ring, unused opcode, clear
    send_item(OP_READ, 8'hA5, 1'b1);
    send_item(OP_UNUSED, 8'hFF, 1'b1);
    send_item(OP_CLEAR, 8'h00, 1'b0);
    // two-byte packet with extreme bytes, read back
    send_item(OP_WRITE, 8'h00, 1'b0);
    send_item(OP_WRITE, 8'hFF, 1'b1);
    send_item(OP_READ, 8'h00, 1'b0);
    send_item(OP_READ, 8'hFF, 1'b1);
    // fill every usable slot, the last commit reports ring now full,
    // then a write into the full ring is dropped
    for (int unsigned i = 0; i < 15; i++) send_item(OP_WRITE, 8'(i * 17), 1'b1);
    send_item(OP_WRITE, 8'h5A, 1'b0);
    send_item(OP_CLEAR, 8'h3C, 1'b1);
    end_phase();

    for (int unsigned p = 0; p < PHASES; p++) begin
      // one stretch without idling, and none at the end of the run
      jitter_on <= (p != 4 && p != PHASES - 1);
      write_limit(9'(limit_steps[p]));
      if (p == 2) begin
        // full-size packet plus one byte past the limit, then drain it
        send_item(OP_CLEAR, 8'h00, 1'b0);
        for (int unsigned i = 0; i < 257; i++)
          send_item(OP_WRITE, 8'($urandom_range(0, 255)), i == 256);
        for (int unsigned i = 0; i < 257; i++)
          send_item(OP_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      run_phase(20, write_pct[p]);
      end_phase();
    end

    repeat (4) @(posedge clk);
    if (ring.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/lpf_pkg.sv
hw/rtl/lpf_ram.sv
hw/rtl/length_prefixed_packet_fifo.sv
dv/testbench.sv
